// ----- rtl/grld_pkg.sv -----
// Package for the Golomb run-length decoder: register indexes, field widths,
// parameter defaults and the decoder phase type. Depends on nothing else.
`timescale 1ns / 1ps
`default_nettype none

package grld_pkg;

  localparam int DefValueWidth = 24;
  localparam int DefMaxK       = 16;

  localparam int CodeSelW  = 5;
  localparam int TotalW    = 24;
  localparam int CfgDataW  = 24;
  localparam int CfgAddrW  = 1;

  localparam logic [CfgAddrW-1:0] RegCodeSelect = 1'b0;
  localparam logic [CfgAddrW-1:0] RegTotalSum   = 1'b1;

  localparam logic [TotalW-1:0]   TotalSumReset = 24'd1;

  typedef enum logic [1:0] {
    PH_PREFIX,
    PH_SEL1,
    PH_SEL2,
    PH_REM
  } phase_e;

endpackage

`default_nettype wire

// ----- rtl/golomb_run_length_decoder.sv -----
// Golomb run-length decoder, one coded bit per item, one module.
// Depends on grld_pkg for register indexes, widths and the phase type.
//
// Usage: coded bits enter on the input channel (in_valid_i, in_stall_o,
// stream_bit_i), one bit per item. When a bit completes a code, one item
// leaves on the output channel (out_valid_o, out_stall_i) carrying the
// decoded run length and a flag set on the value that brings the block sum
// to at least total_sum. Bits that do not complete a code yield no item.
// The item is registered and appears in the cycle after its completing bit.
// Throughput: one bit per cycle while in_stall_o is low; each bit updates the
// phase, prefix, remainder, count and offset registers, and a completed code
// the block sum, via add-and-saturate paths. The output register lets the next
// bit be taken while a result is being delivered; in_stall_o rises only while
// a result waits and the receiver stalls, and the waiting result holds steady.
// Reset clears the decode state, the block sum and the output valid, and
// sets code_select to 0 and total_sum to 1. Configuration is written with
// cfg_we_i, cfg_addr_i and cfg_wdata_i.
`timescale 1ns / 1ps
`default_nettype none

module golomb_run_length_decoder #(
  parameter int VALUE_WIDTH = grld_pkg::DefValueWidth,
  parameter int MAX_K       = grld_pkg::DefMaxK
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_we_i,
  input  wire logic [grld_pkg::CfgAddrW-1:0] cfg_addr_i,
  input  wire logic [grld_pkg::CfgDataW-1:0] cfg_wdata_i,
  input  wire logic                          in_valid_i,
  output logic                               in_stall_o,
  input  wire logic                          stream_bit_i,
  output logic                               out_valid_o,
  input  wire logic                          out_stall_i,
  output logic [VALUE_WIDTH-1:0]             run_value_o,
  output logic                               last_run_o
);

  localparam int KW   = $clog2(MAX_K + 2);
  localparam int OffW = MAX_K + 2;
  localparam int AW   = ((VALUE_WIDTH > OffW) ? VALUE_WIDTH : OffW) + 2;
  localparam int BsW  = ((VALUE_WIDTH > grld_pkg::TotalW) ?
                         VALUE_WIDTH : grld_pkg::TotalW) + 1;
  localparam logic [AW-1:0] VMax = AW'({VALUE_WIDTH{1'b1}});

  logic [grld_pkg::CodeSelW-1:0] code_sel_q;
  logic [grld_pkg::TotalW-1:0]   total_q;

  grld_pkg::phase_e phase_q, phase_d;
  logic [VALUE_WIDTH-1:0] prefix_q, prefix_d;
  logic [MAX_K-1:0]       rem_q, rem_d;
  logic [KW-1:0]          left_q, left_d;
  logic [OffW-1:0]        off_q, off_d;
  logic [BsW-1:0]         block_q, block_d;

  logic                   out_valid_q;
  logic [VALUE_WIDTH-1:0] value_q;
  logic                   last_q;

  logic                   fire;
  logic                   emit;
  logic                   odd;
  logic [4:0]             k_raw;
  logic [KW-1:0]          k;
  logic [OffW-1:0]        m;
  logic [AW-1:0]          prefix_sum;
  logic [AW-1:0]          value_sum;
  logic [VALUE_WIDTH-1:0] value;
  logic [BsW-1:0]         block_sum;
  logic                   last;
  logic [KW-1:0]          left_dec;

  assign in_stall_o  = out_valid_q && out_stall_i;
  assign fire        = in_valid_i && !in_stall_o;
  assign out_valid_o = out_valid_q;
  assign run_value_o = value_q;
  assign last_run_o  = last_q;

  assign odd   = code_sel_q[0];
  assign k_raw = {1'b0, code_sel_q[4:1]} + {4'd0, !odd};
  assign k     = (k_raw > 5'(MAX_K)) ? KW'(MAX_K) : KW'(k_raw);
  assign m     = odd ? (OffW'(3) << k) : (OffW'(1) << k);

  assign prefix_sum = AW'(prefix_q) + AW'(m);
  assign left_dec   = (left_q == '0) ? '0 : left_q - KW'(1);

  // Next phase.
  always_comb begin
    phase_d = phase_q;
    unique case (phase_q)
      grld_pkg::PH_PREFIX: begin
        if (!stream_bit_i) begin
          if (odd) begin
            phase_d = grld_pkg::PH_SEL1;
          end else if (k != '0) begin
            phase_d = grld_pkg::PH_REM;
          end
        end
      end
      grld_pkg::PH_SEL1: begin
        if (stream_bit_i) begin
          phase_d = grld_pkg::PH_SEL2;
        end else if (k != '0) begin
          phase_d = grld_pkg::PH_REM;
        end else begin
          phase_d = grld_pkg::PH_PREFIX;
        end
      end
      grld_pkg::PH_SEL2: begin
        phase_d = (k != '0) ? grld_pkg::PH_REM : grld_pkg::PH_PREFIX;
      end
      grld_pkg::PH_REM: begin
        if (left_dec == '0) begin
          phase_d = grld_pkg::PH_PREFIX;
        end
      end
      default: phase_d = grld_pkg::PH_PREFIX;
    endcase
  end

  // Datapath and result.
  always_comb begin
    emit     = 1'b0;
    prefix_d = prefix_q;
    rem_d    = rem_q;
    left_d   = left_q;
    off_d    = off_q;
    unique case (phase_q)
      grld_pkg::PH_PREFIX: begin
        if (stream_bit_i) begin
          prefix_d = (prefix_sum > VMax) ? VMax[VALUE_WIDTH-1:0]
                                         : prefix_sum[VALUE_WIDTH-1:0];
        end else begin
          off_d = '0;
          if (!odd) begin
            if (k == '0) begin
              emit = 1'b1;
            end else begin
              rem_d  = '0;
              left_d = k;
            end
          end
        end
      end
      grld_pkg::PH_SEL1: begin
        if (!stream_bit_i) begin
          off_d = '0;
          if (k == '0) begin
            emit = 1'b1;
          end else begin
            rem_d  = '0;
            left_d = k;
          end
        end
      end
      grld_pkg::PH_SEL2: begin
        off_d = stream_bit_i ? (OffW'(1) << (k + KW'(1))) : (OffW'(1) << k);
        if (k == '0) begin
          emit = 1'b1;
        end else begin
          rem_d  = '0;
          left_d = k;
        end
      end
      grld_pkg::PH_REM: begin
        rem_d  = MAX_K'({rem_q, stream_bit_i});
        left_d = left_dec;
        emit   = (left_dec == '0);
      end
      default: emit = 1'b0;
    endcase

    value_sum = AW'(prefix_q) + AW'(off_d) + AW'(rem_d) + AW'(1);
    value     = (value_sum > VMax) ? VMax[VALUE_WIDTH-1:0]
                                   : value_sum[VALUE_WIDTH-1:0];
    block_sum = block_q + BsW'(value);
    last      = (block_sum >= BsW'(total_q));
    block_d   = last ? '0 : block_sum;

    if (emit) begin
      prefix_d = '0;
      rem_d    = '0;
      left_d   = '0;
      off_d    = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      code_sel_q <= '0;
      total_q    <= grld_pkg::TotalSumReset;
    end else if (cfg_we_i) begin
      unique case (cfg_addr_i)
        grld_pkg::RegCodeSelect: code_sel_q <= cfg_wdata_i[grld_pkg::CodeSelW-1:0];
        grld_pkg::RegTotalSum:   total_q    <= cfg_wdata_i[grld_pkg::TotalW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= grld_pkg::PH_PREFIX;
      prefix_q <= '0;
      rem_q    <= '0;
      left_q   <= '0;
      off_q    <= '0;
      block_q  <= '0;
    end else if (fire) begin
      phase_q  <= phase_d;
      prefix_q <= prefix_d;
      rem_q    <= rem_d;
      left_q   <= left_d;
      off_q    <= off_d;
      if (emit) begin
        block_q <= block_d;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (fire && emit) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire && emit) begin
      value_q <= value;
      last_q  <= last;
    end
  end

endmodule

`default_nettype wire
